FILE: rtl/core/ttgr_pkg.sv
// Types, constants and the 5x7 font table for the text terminal glyph renderer.
// Used by every module of the renderer core; no dependencies.
package ttgr_pkg;

  localparam int CELL_WIDTH  = 6;
  localparam int CELL_HEIGHT = 8;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COUNT = 95;
  localparam int CMDQ_DEPTH  = 2;

  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_RETURN    = 8'd13;
  localparam logic [7:0] CHAR_FIRST     = 8'd32;
  localparam logic [7:0] CHAR_LAST      = 8'd126;

  localparam logic [1:0] KIND_PIXELS = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic       MODE_CHAR  = 1'b0;
  localparam logic       MODE_CLEAR = 1'b1;

  localparam logic       CFG_FG_COLOR = 1'b0;
  localparam logic       CFG_BG_COLOR = 1'b1;

  localparam logic [15:0] FG_COLOR_RESET = 16'h07E0;
  localparam logic [15:0] BG_COLOR_RESET = 16'h0000;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pixel_addr;
    logic [15:0] pix0;
    logic [15:0] pix1;
    logic [15:0] pix2;
    logic [15:0] pix3;
    logic [15:0] pix4;
    logic [15:0] pix5;
    logic        last;
  } out_item_t;

  // One queued job: a clear, or an optional scroll followed by an optional cell draw.
  typedef struct packed {
    logic        clear;
    logic        scroll;
    logic        draw;
    logic [6:0]  glyph;
    logic [15:0] addr;
  } cmd_t;

  // Font columns 0..4 from the most significant byte down; bit y is glyph row y.
  localparam logic [39:0] FONT_ROM [0:GLYPH_COUNT-1] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700,
    40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001C224100,
    40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000,
    40'h0041360800, 40'h08082A1C08
  };

endpackage

FILE: rtl/core/text_terminal_glyph_renderer_core.sv
// Text terminal glyph renderer: takes character bytes or a clear command, keeps a cursor
// on a COLUMNS x ROWS grid of 6x8 cells, and emits framebuffer writes. A drawn character
// (printable byte, any other non-CR/LF byte as a space, or a backspace blank) produces eight
// pixel-row beats, one per cycle on the result port while out_stall is low;
// a wrap past the bottom row adds one scroll beat. Clear and bottom-row newline produce a
// single beat, carriage return none. One result beat per cycle, unless out_stall holds it, sets the rate;
// a two-job queue lets input beats be taken while results are still being delivered.
// Depends on ttgr_pkg, ttgr_front, ttgr_cmd_fifo and ttgr_back.
module text_terminal_glyph_renderer_core #(
  parameter int COLUMNS            = 53,
  parameter int ROWS               = 25,
  parameter int SCREEN_PIXELS_WIDE = 320
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ttgr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ttgr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import ttgr_pkg::*;

  logic [15:0] fg_color_r;
  logic [15:0] bg_color_r;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_not_empty;
  cmd_t        push_cmd;
  cmd_t        pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r <= FG_COLOR_RESET;
      bg_color_r <= BG_COLOR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FG_COLOR: fg_color_r <= cfg_data;
        CFG_BG_COLOR: bg_color_r <= cfg_data;
        default:      fg_color_r <= fg_color_r;
      endcase
    end
  end

  ttgr_front #(
    .COLUMNS           (COLUMNS),
    .ROWS              (ROWS),
    .SCREEN_PIXELS_WIDE(SCREEN_PIXELS_WIDE)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (push_cmd)
  );

  ttgr_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_cmd),
    .not_empty(q_not_empty)
  );

  ttgr_back #(
    .SCREEN_PIXELS_WIDE(SCREEN_PIXELS_WIDE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .fg_color   (fg_color_r),
    .bg_color   (bg_color_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

FILE: rtl/core/ttgr_front.sv
// Front end: accepts input beats, tracks the text cursor and queues render jobs.
// Depends on ttgr_pkg.
module ttgr_front #(
  parameter int COLUMNS            = 53,
  parameter int ROWS               = 25,
  parameter int SCREEN_PIXELS_WIDE = 320
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ttgr_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output ttgr_pkg::cmd_t    q_cmd
);
  import ttgr_pkg::*;

  localparam int COL_W     = $clog2(COLUMNS + 1);
  localparam int ROW_W     = $clog2(ROWS + 1);
  localparam int ROW_PITCH = CELL_HEIGHT * SCREEN_PIXELS_WIDE;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             accept;
  logic             at_bottom;
  logic             wrap;
  logic [COL_W-1:0] draw_col;
  logic [ROW_W-1:0] draw_row;
  logic [31:0]      addr_full;
  logic [7:0]       code;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign code      = in_data.char_code;
  assign at_bottom = (row_r == ROW_W'(ROWS - 1));
  assign wrap      = (col_r >= COL_W'(COLUMNS));
  assign addr_full = 32'(draw_row) * 32'(ROW_PITCH) + 32'(draw_col) * 32'(CELL_WIDTH) + 32'd1;

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    draw_col     = col_r;
    draw_row     = row_r;
    q_cmd.clear  = 1'b0;
    q_cmd.scroll = 1'b0;
    q_cmd.draw   = 1'b0;
    q_cmd.glyph  = '0;
    if (in_data.mode == MODE_CLEAR) begin
      col_nxt     = '0;
      row_nxt     = '0;
      q_cmd.clear = 1'b1;
    end else if (code == CHAR_RETURN) begin
      col_nxt = col_r;
    end else if (code == CHAR_NEWLINE) begin
      col_nxt      = '0;
      row_nxt      = at_bottom ? row_r : row_r + 1'b1;
      q_cmd.scroll = at_bottom;
    end else if (code == CHAR_BACKSPACE) begin
      if (col_r != '0) begin
        draw_col   = col_r - 1'b1;
        col_nxt    = draw_col;
        q_cmd.draw = 1'b1;
      end
    end else begin
      if (wrap) begin
        draw_col     = '0;
        draw_row     = at_bottom ? row_r : row_r + 1'b1;
        q_cmd.scroll = at_bottom;
      end
      col_nxt    = draw_col + 1'b1;
      row_nxt    = draw_row;
      q_cmd.draw = 1'b1;
      if (code >= CHAR_FIRST && code <= CHAR_LAST) begin
        q_cmd.glyph = 7'(code - CHAR_FIRST);
      end
    end
    q_cmd.addr = addr_full[15:0];
  end

  assign q_push = accept && (q_cmd.clear || q_cmd.scroll || q_cmd.draw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: rtl/core/ttgr_cmd_fifo.sv
// Short job queue between the cursor front end and the result back end.
// Depends on ttgr_pkg.
module ttgr_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttgr_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output ttgr_pkg::cmd_t pop_data,
  output logic           not_empty
);
  import ttgr_pkg::*;

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(CMDQ_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("job queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CMDQ_DEPTH)) else $error("job queue count out of range");

endmodule

FILE: rtl/core/ttgr_back.sv
// Back end: expands queued jobs into scroll, clear and pixel-row result beats.
// Depends on ttgr_pkg; reads the glyph table from it.
module ttgr_back #(
  parameter int SCREEN_PIXELS_WIDE = 320
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  ttgr_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  input  logic [15:0]        fg_color,
  input  logic [15:0]        bg_color,
  output logic               out_valid,
  input  logic               out_stall,
  output ttgr_pkg::out_item_t out_data
);
  import ttgr_pkg::*;

  cmd_t        cur_r;
  logic        cur_v_r;
  logic [2:0]  y_r;
  out_item_t   out_r, out_nxt;
  logic        out_valid_r;
  logic        can_emit;
  logic        emit;
  logic        last_beat;
  logic        done;
  logic [39:0] glyph_bits;
  logic [15:0] pix [CELL_WIDTH];

  assign can_emit   = !out_valid_r || !out_stall;
  assign emit       = can_emit && cur_v_r;
  assign last_beat  = cur_r.clear || (cur_r.scroll ? !cur_r.draw : (y_r == 3'd7));
  assign done       = emit && last_beat;
  assign q_pop      = can_emit && (!cur_v_r || done) && q_not_empty;
  assign glyph_bits = FONT_ROM[cur_r.glyph];

  always_comb begin
    for (int x = 0; x < CELL_WIDTH; x++) begin
      pix[x] = bg_color;
    end
    for (int x = 0; x < GLYPH_COLS; x++) begin
      if (y_r < 3'(GLYPH_ROWS) && glyph_bits[(GLYPH_COLS - 1 - x) * 8 + int'(y_r)]) begin
        pix[x] = fg_color;
      end
    end
  end

  always_comb begin
    out_nxt.kind       = KIND_PIXELS;
    out_nxt.pixel_addr = cur_r.addr;
    out_nxt.pix0       = pix[0];
    out_nxt.pix1       = pix[1];
    out_nxt.pix2       = pix[2];
    out_nxt.pix3       = pix[3];
    out_nxt.pix4       = pix[4];
    out_nxt.pix5       = pix[5];
    out_nxt.last       = last_beat;
    if (cur_r.clear || cur_r.scroll) begin
      out_nxt.kind       = cur_r.clear ? KIND_CLEAR : KIND_SCROLL;
      out_nxt.pixel_addr = '0;
      out_nxt.pix0       = bg_color;
      out_nxt.pix1       = bg_color;
      out_nxt.pix2       = bg_color;
      out_nxt.pix3       = bg_color;
      out_nxt.pix4       = bg_color;
      out_nxt.pix5       = bg_color;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
      y_r   <= '0;
    end else if (emit && !cur_r.clear) begin
      if (cur_r.scroll) begin
        cur_r.scroll <= 1'b0;
      end else begin
        y_r        <= y_r + 1'b1;
        cur_r.addr <= cur_r.addr + 16'(SCREEN_PIXELS_WIDE);
      end
    end
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_v_r <= 1'b1;
      end else if (done) begin
        cur_v_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (can_emit) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_clear_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == KIND_CLEAR |-> out_r.last)
    else $error("clear beat not marked last");
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.kind != 2'd3) else $error("illegal result kind");
  a_pop_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && cur_v_r |-> done) else $error("job dropped before finishing");

endmodule

FILE: tb/sv/text_terminal_glyph_renderer_core_tb.sv
// Self-checking bench for text_terminal_glyph_renderer_core: tracks the cursor and colors,
// predicts every pixel-row, scroll and clear beat, and checks them in order under idling.
// Depends on ttgr_pkg and the renderer core RTL.
`timescale 1ns / 1ps

module text_terminal_glyph_renderer_core_tb;
  import ttgr_pkg::*;

  localparam int COLUMNS            = 53;
  localparam int ROWS               = 25;
  localparam int SCREEN_PIXELS_WIDE = 320;
  localparam int DRAIN_CYCLES       = 32;
  localparam int STUCK_LIMIT        = 4000;

  localparam logic [39:0] GLYPHS [0:94] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_FG_COLOR;
  logic [15:0] cfg_data = '0;

  in_item_t    keystrokes [$];
  out_item_t   fb_writes_due [$];
  logic [15:0] ink_color = FG_COLOR_RESET;
  logic [15:0] paper_color = BG_COLOR_RESET;
  int          caret_col = 0;
  int          caret_row = 0;
  bit          in_taken = 1'b0;
  bit          item_held = 1'b0;
  bit          quiet = 1'b0;
  bit          failed = 1'b0;
  int          send_gap = 0;
  int          sink_gap = 0;
  int          stuck_cycles = 0;

  text_terminal_glyph_renderer_core #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS),
    .SCREEN_PIXELS_WIDE(SCREEN_PIXELS_WIDE)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic in_item_t make_item(logic mode, logic [7:0] code);
    in_item_t it;
    it.mode = mode;
    it.char_code = code;
    return it;
  endfunction

  function automatic out_item_t fill_beat(logic [1:0] kind);
    out_item_t b;
    b.kind = kind;
    b.pixel_addr = '0;
    b.pix0 = paper_color;
    b.pix1 = paper_color;
    b.pix2 = paper_color;
    b.pix3 = paper_color;
    b.pix4 = paper_color;
    b.pix5 = paper_color;
    b.last = 1'b0;
    return b;
  endfunction

  function automatic out_item_t glyph_beat(int code, int y);
    out_item_t   b;
    logic [15:0] px [6];
    logic [39:0] cols;
    int          x;
    int          addr;
    cols = GLYPHS[code - 32];
    for (x = 0; x < 6; x++) begin
      px[x] = (x < 5 && y < 7 && cols[(4 - x) * 8 + y]) ? ink_color : paper_color;
    end
    addr = (caret_row * CELL_HEIGHT + y) * SCREEN_PIXELS_WIDE + caret_col * CELL_WIDTH + 1;
    b.kind = KIND_PIXELS;
    b.pixel_addr = addr[15:0];
    b.pix0 = px[0];
    b.pix1 = px[1];
    b.pix2 = px[2];
    b.pix3 = px[3];
    b.pix4 = px[4];
    b.pix5 = px[5];
    b.last = 1'b0;
    return b;
  endfunction

  task automatic draw_glyph(logic [7:0] code);
    int glyph;
    int y;
    glyph = (code < CHAR_FIRST || code > CHAR_LAST) ? int'(CHAR_FIRST) : int'(code);
    for (y = 0; y < CELL_HEIGHT; y++) fb_writes_due.push_back(glyph_beat(glyph, y));
  endtask

  task automatic advance_row();
    caret_col = 0;
    caret_row++;
    if (caret_row >= ROWS) begin
      caret_row = ROWS - 1;
      fb_writes_due.push_back(fill_beat(KIND_SCROLL));
    end
  endtask

  task automatic render_byte(in_item_t it);
    int        queued;
    out_item_t tail;
    queued = fb_writes_due.size();
    if (it.mode == MODE_CLEAR) begin
      caret_col = 0;
      caret_row = 0;
      fb_writes_due.push_back(fill_beat(KIND_CLEAR));
    end else if (it.char_code == CHAR_RETURN) begin
    end else if (it.char_code == CHAR_NEWLINE) begin
      advance_row();
    end else if (it.char_code == CHAR_BACKSPACE) begin
      if (caret_col > 0) begin
        caret_col--;
        draw_glyph(CHAR_FIRST);
      end
    end else begin
      if (caret_col >= COLUMNS) advance_row();
      draw_glyph(it.char_code);
      caret_col++;
    end
    if (fb_writes_due.size() > queued) begin
      tail = fb_writes_due.pop_back();
      tail.last = 1'b1;
      fb_writes_due.push_back(tail);
    end
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // monitor: predict on each accepted input beat, then check the result beat
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
      stuck_cycles = 0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (in_taken) render_byte(in_data);
      if (out_valid && !out_stall) begin
        if (fb_writes_due.size() == 0) begin
          $display("%0t: unexpected beat expected none actual %h", $time, out_data);
          failed = 1'b1;
        end else begin
          want = fb_writes_due.pop_front();
          compare_field("kind", 16'(want.kind), 16'(out_data.kind));
          compare_field("pixel_addr", want.pixel_addr, out_data.pixel_addr);
          compare_field("pix0", want.pix0, out_data.pix0);
          compare_field("pix1", want.pix1, out_data.pix1);
          compare_field("pix2", want.pix2, out_data.pix2);
          compare_field("pix3", want.pix3, out_data.pix3);
          compare_field("pix4", want.pix4, out_data.pix4);
          compare_field("pix5", want.pix5, out_data.pix5);
          compare_field("last", 16'(want.last), 16'(out_data.last));
        end
      end
      if (in_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, STUCK_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // driver: hold a beat until taken, otherwise idle or load the next one
  always @(negedge clk) begin
    if (item_held && in_taken) item_held = 1'b0;
    if (!item_held) begin
      if (send_gap == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 15);
      end
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (keystrokes.size() != 0) begin
        in_data <= keystrokes.pop_front();
        in_valid <= 1'b1;
        item_held = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (sink_gap == 0 && !quiet && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(1, 15);
    end
    if (sink_gap != 0) begin
      sink_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic settle();
    while (keystrokes.size() != 0 || item_held || fb_writes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FG_COLOR) begin
      ink_color = value;
    end else begin
      paper_color = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_mixed(input int count);
    int k;
    int pick;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        keystrokes.push_back(make_item(MODE_CHAR, 8'($urandom_range(32, 126))));
      end else if (pick < 70) begin
        keystrokes.push_back(make_item(MODE_CHAR, CHAR_NEWLINE));
      end else if (pick < 78) begin
        keystrokes.push_back(make_item(MODE_CHAR, CHAR_BACKSPACE));
      end else if (pick < 82) begin
        keystrokes.push_back(make_item(MODE_CHAR, CHAR_RETURN));
      end else if (pick < 96) begin
        keystrokes.push_back(make_item(MODE_CHAR, 8'($urandom_range(0, 255))));
      end else begin
        keystrokes.push_back(make_item(MODE_CLEAR, 8'($urandom_range(0, 255))));
      end
    end
  endtask

  initial begin
    int k;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    keystrokes.push_back(make_item(MODE_CHAR, 8'h41));
    keystrokes.push_back(make_item(MODE_CHAR, CHAR_FIRST));
    keystrokes.push_back(make_item(MODE_CHAR, CHAR_LAST));
    keystrokes.push_back(make_item(MODE_CHAR, 8'h21));
    keystrokes.push_back(make_item(MODE_CHAR, 8'h7F));
    keystrokes.push_back(make_item(MODE_CHAR, 8'h1F));
    keystrokes.push_back(make_item(MODE_CHAR, 8'hFF));
    keystrokes.push_back(make_item(MODE_CHAR, 8'h00));
    keystrokes.push_back(make_item(MODE_CHAR, 8'h80));
    keystrokes.push_back(make_item(MODE_CHAR, CHAR_RETURN));
    keystrokes.push_back(make_item(MODE_CHAR, CHAR_BACKSPACE));
    keystrokes.push_back(make_item(MODE_CHAR, CHAR_NEWLINE));
    keystrokes.push_back(make_item(MODE_CHAR, CHAR_BACKSPACE));
    keystrokes.push_back(make_item(MODE_CHAR, 8'h55));
    keystrokes.push_back(make_item(MODE_CHAR, 8'hAA));
    keystrokes.push_back(make_item(MODE_CHAR, 8'h7D));
    keystrokes.push_back(make_item(MODE_CLEAR, 8'hFF));
    keystrokes.push_back(make_item(MODE_CHAR, CHAR_BACKSPACE));
    keystrokes.push_back(make_item(MODE_CHAR, 8'h30));
    keystrokes.push_back(make_item(MODE_CLEAR, 8'h00));
    settle();

    write_reg(CFG_FG_COLOR, 16'hFFFF);
    write_reg(CFG_BG_COLOR, 16'h0000);
    queue_mixed(20);
    settle();

    // walk to the bottom row, scroll, then fill and wrap a full line there
    write_reg(CFG_FG_COLOR, 16'h0000);
    write_reg(CFG_BG_COLOR, 16'hFFFF);
    keystrokes.push_back(make_item(MODE_CLEAR, 8'($urandom_range(0, 255))));
    for (k = 0; k < ROWS + 1; k++) keystrokes.push_back(make_item(MODE_CHAR, CHAR_NEWLINE));
    for (k = 0; k < COLUMNS; k++) begin
      keystrokes.push_back(make_item(MODE_CHAR, 8'($urandom_range(32, 126))));
    end
    keystrokes.push_back(make_item(MODE_CHAR, CHAR_BACKSPACE));
    keystrokes.push_back(make_item(MODE_CHAR, 8'($urandom_range(32, 126))));
    keystrokes.push_back(make_item(MODE_CHAR, 8'($urandom_range(32, 126))));
    for (k = 0; k < 3; k++) keystrokes.push_back(make_item(MODE_CHAR, CHAR_BACKSPACE));
    settle();

    write_reg(CFG_FG_COLOR, 16'($urandom_range(0, 65535)));
    write_reg(CFG_BG_COLOR, 16'($urandom_range(0, 65535)));
    quiet = 1'b1;
    queue_mixed(30);
    settle();

    if (!failed && fb_writes_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
